// ===== src/frfc_pkg.sv =====
// Shared types and constants for the framed byte ring with commit and abort.
package frfc_pkg;

    localparam int RING_BYTES_DEF = 16384;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_INDEX_W    = 2;
    localparam int SLACK_W        = 13;
    localparam int LEN_BYTES      = 4;
    localparam int LEN_CNT_W      = 2;

    localparam logic [SLACK_W-1:0] SLACK_RESET = 13'd200;

    localparam logic [CFG_INDEX_W-1:0] CFG_TYPE_EN   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TYPE_CODE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLACK     = 2'd2;

    typedef enum logic [2:0] {
        MODE_WRITE = 3'd0,
        MODE_BEGIN = 3'd1,
        MODE_END   = 3'd2,
        MODE_ABORT = 3'd3,
        MODE_READ  = 3'd4,
        MODE_DONE  = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_NOTHING = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_KIND,
        S_LEN
    } state_t;

    typedef struct packed {
        logic    strobe;
        logic    rvalid;
        status_t status;
        logic    done;
    } result_t;

endpackage

// ===== src/frfc_ram.sv =====
// Byte ring store: one write port, one registered read port.
module frfc_ram #(
    parameter int RING_BYTES = frfc_pkg::RING_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(RING_BYTES)-1:0] waddr,
    input  logic [7:0]                    wdata,
    input  logic                          re,
    input  logic [$clog2(RING_BYTES)-1:0] raddr,
    output logic [7:0]                    rdata
);

    logic [7:0] mem [RING_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/frfc_level.sv =====
// Fill level reporting: free space less slack and the flush flag.
module frfc_level #(
    parameter int RING_BYTES = frfc_pkg::RING_BYTES_DEF
) (
    input  logic [$clog2(RING_BYTES)-1:0] wp,
    input  logic [$clog2(RING_BYTES)-1:0] rp,
    input  logic [$clog2(RING_BYTES)-1:0] cp,
    input  logic [frfc_pkg::SLACK_W-1:0]  slack,
    output logic [$clog2(RING_BYTES):0]   free_bytes,
    output logic                          flush_due
);
    import frfc_pkg::*;

    localparam int PTR_W  = $clog2(RING_BYTES);
    localparam int FREE_W = PTR_W + 1;
    localparam int CMP_W  = (FREE_W > SLACK_W) ? FREE_W : SLACK_W;
    localparam logic [PTR_W-1:0] FLUSH_AT = PTR_W'(RING_BYTES * 3 / 4);

    logic [PTR_W-1:0]  filled;
    logic [PTR_W-1:0]  uncommitted;
    logic [FREE_W-1:0] raw_free;
    logic [CMP_W-1:0]  free_ext;
    logic [CMP_W-1:0]  slack_ext;
    logic [CMP_W-1:0]  diff;

    assign filled      = wp - rp;
    assign uncommitted = wp - cp;
    assign raw_free    = FREE_W'(RING_BYTES) - {1'b0, filled};
    assign free_ext    = CMP_W'(raw_free);
    assign slack_ext   = CMP_W'(slack);
    assign diff        = free_ext - slack_ext;
    assign free_bytes  = (free_ext > slack_ext) ? diff[FREE_W-1:0] : '0;
    assign flush_due   = (uncommitted >= FLUSH_AT);

endmodule

// ===== src/frfc_ctrl.sv =====
// Request sequencer: pointers, configuration and ring store write/read control.
module frfc_ctrl #(
    parameter int RING_BYTES = frfc_pkg::RING_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [2:0]                        mode,
    input  logic [7:0]                        data_byte,
    input  logic [7:0]                        frame_kind,
    input  logic                              cfg_we,
    input  logic [frfc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [frfc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              mem_we,
    output logic [$clog2(RING_BYTES)-1:0]     mem_waddr,
    output logic [7:0]                        mem_wdata,
    output logic                              mem_re,
    output logic [$clog2(RING_BYTES)-1:0]     mem_raddr,
    output logic [$clog2(RING_BYTES)-1:0]     wp,
    output logic [$clog2(RING_BYTES)-1:0]     rp,
    output logic [$clog2(RING_BYTES)-1:0]     cp,
    output logic [frfc_pkg::SLACK_W-1:0]      slack,
    output frfc_pkg::result_t                 result
);
    import frfc_pkg::*;

    localparam int PTR_W = $clog2(RING_BYTES);
    localparam int LEN_W = (PTR_W > 8) ? PTR_W : 8;
    localparam logic [PTR_W-1:0]     RING_MASK = PTR_W'(RING_BYTES - 1);
    localparam logic [LEN_CNT_W-1:0] LEN_LAST  = LEN_CNT_W'(LEN_BYTES - 1);

    state_t               state_reg, state_next;
    logic [PTR_W-1:0]     wp_reg, wp_next;
    logic [PTR_W-1:0]     cp_reg, cp_next;
    logic [PTR_W-1:0]     rp_reg, rp_next;
    logic                 done_reg, done_next;
    logic                 tl_reg;
    logic [7:0]           code_reg;
    logic [SLACK_W-1:0]   slack_reg;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [PTR_W-1:0]     patch_reg, patch_next;
    logic [LEN_CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]           kind_reg, kind_next;
    result_t              res_reg, res_next;

    logic                 accept;
    logic [PTR_W-1:0]     dist_rw;
    logic [PTR_W-1:0]     used_cw;
    logic                 room_write;
    logic                 room_begin;
    logic                 frame_empty;
    logic [PTR_W-1:0]     frame_len;
    logic [PTR_W:0]       hdr_len;

    assign accept      = start && (state_reg == S_IDLE);
    assign dist_rw     = wp_reg - rp_reg;
    assign used_cw     = wp_reg - cp_reg;
    assign room_write  = ~&dist_rw;
    assign hdr_len     = tl_reg ? (PTR_W + 1)'(6) : (PTR_W + 1)'(5);
    assign room_begin  = ({1'b0, dist_rw} + hdr_len) <= {1'b0, RING_MASK};
    assign frame_empty = {1'b0, used_cw} <= hdr_len;
    assign frame_len   = used_cw - (tl_reg ? PTR_W'(5) : PTR_W'(4));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((mode_t'(mode) == MODE_BEGIN) && room_begin && tl_reg)
                    begin
                        state_next = S_KIND;
                    end
                    else if ((mode_t'(mode) == MODE_END) && !frame_empty)
                    begin
                        state_next = S_LEN;
                    end
                end
            end
            S_KIND:
            begin
                state_next = S_IDLE;
            end
            S_LEN:
            begin
                if (cnt_reg == LEN_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        wp_next    = wp_reg;
        cp_next    = cp_reg;
        rp_next    = rp_reg;
        done_next  = done_reg;
        len_next   = len_reg;
        patch_next = patch_reg;
        cnt_next   = cnt_reg;
        kind_next  = kind_reg;
        res_next   = '{strobe: 1'b0, rvalid: 1'b0, status: STAT_OK, done: done_reg};
        mem_we     = 1'b0;
        mem_waddr  = wp_reg;
        mem_wdata  = data_byte;
        mem_re     = 1'b0;
        mem_raddr  = rp_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next.strobe = 1'b1;
                    unique case (mode_t'(mode))
                        MODE_WRITE:
                        begin
                            if (room_write)
                            begin
                                mem_we  = 1'b1;
                                wp_next = wp_reg + PTR_W'(1);
                            end
                            else
                            begin
                                res_next.status = STAT_FULL;
                            end
                        end
                        MODE_BEGIN:
                        begin
                            if (!room_begin)
                            begin
                                res_next.status = STAT_FULL;
                            end
                            else if (tl_reg)
                            begin
                                mem_we          = 1'b1;
                                mem_wdata       = code_reg;
                                kind_next       = frame_kind;
                                res_next.strobe = 1'b0;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = wp_reg + PTR_W'(4);
                                mem_wdata = frame_kind;
                                wp_next   = wp_reg + PTR_W'(5);
                            end
                        end
                        MODE_END:
                        begin
                            if (frame_empty)
                            begin
                                wp_next         = cp_reg;
                                res_next.status = STAT_EMPTY;
                            end
                            else
                            begin
                                len_next        = LEN_W'(frame_len);
                                patch_next      = cp_reg + PTR_W'(tl_reg);
                                cnt_next        = '0;
                                res_next.strobe = 1'b0;
                            end
                        end
                        MODE_ABORT:
                        begin
                            wp_next = cp_reg;
                        end
                        MODE_READ:
                        begin
                            if (rp_reg == cp_reg)
                            begin
                                res_next.status = STAT_NOTHING;
                            end
                            else
                            begin
                                mem_re          = 1'b1;
                                rp_next         = rp_reg + PTR_W'(1);
                                res_next.rvalid = 1'b1;
                            end
                        end
                        MODE_DONE:
                        begin
                            done_next     = 1'b1;
                            res_next.done = 1'b1;
                        end
                        default:
                        begin
                            res_next.status = STAT_OK;
                        end
                    endcase
                end
            end
            S_KIND:
            begin
                mem_we          = 1'b1;
                mem_waddr       = wp_reg + PTR_W'(5);
                mem_wdata       = kind_reg;
                wp_next         = wp_reg + PTR_W'(6);
                res_next.strobe = 1'b1;
            end
            S_LEN:
            begin
                mem_we     = 1'b1;
                mem_waddr  = patch_reg;
                mem_wdata  = len_reg[7:0];
                len_next   = len_reg >> 8;
                patch_next = patch_reg + PTR_W'(1);
                cnt_next   = cnt_reg + LEN_CNT_W'(1);
                if (cnt_reg == LEN_LAST)
                begin
                    cp_next         = wp_reg;
                    res_next.strobe = 1'b1;
                end
            end
            default:
            begin
                res_next.strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wp_reg    <= '0;
            cp_reg    <= '0;
            rp_reg    <= '0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            res_reg   <= '{strobe: 1'b0, rvalid: 1'b0, status: STAT_OK, done: 1'b0};
            tl_reg    <= 1'b0;
            code_reg  <= '0;
            slack_reg <= SLACK_RESET;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            cp_reg    <= cp_next;
            rp_reg    <= rp_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            res_reg   <= res_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TYPE_EN:   tl_reg    <= cfg_data[0];
                    CFG_TYPE_CODE: code_reg  <= cfg_data[7:0];
                    CFG_SLACK:     slack_reg <= cfg_data[SLACK_W-1:0];
                    default:       tl_reg    <= tl_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg   <= len_next;
        patch_reg <= patch_next;
        kind_reg  <= kind_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign wp     = wp_reg;
    assign rp     = rp_reg;
    assign cp     = cp_reg;
    assign slack  = slack_reg;
    assign result = res_reg;

endmodule

// ===== src/framed_ring_fifo_commit.sv =====
// Top level of the framed byte ring with write, commit and read pointers.
//
//  channel   handshake                  payload
//  request   start, busy                mode, data_byte, frame_kind
//  result    result_strobe              read_byte, read_valid, free_bytes,
//                                       flush_due, stream_done, status
//  config    cfg_we                     cfg_index, cfg_data
//
//  Write, read, abort, done and a begin frame without the type byte finish in
//  the accepting cycle; a begin frame with the type byte goes on to S_KIND
//  (two ring store writes); an end frame that commits goes on to S_LEN (four
//  length byte writes on the one store write port); the result is registered
//  from the last step. busy is high while a request is in its later cycles;
//  start is ignored then. rst_n clears pointers, done mark and configuration;
//  the ring store is not cleared. The receiver cannot stall the result.
module framed_ring_fifo_commit #(
    parameter int RING_BYTES = frfc_pkg::RING_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [2:0]                       mode,
    input  logic [7:0]                       data_byte,
    input  logic [7:0]                       frame_kind,
    input  logic                             cfg_we,
    input  logic [frfc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [frfc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                             result_strobe,
    output logic [7:0]                       read_byte,
    output logic                             read_valid,
    output logic [$clog2(RING_BYTES):0]      free_bytes,
    output logic                             flush_due,
    output logic                             stream_done,
    output logic [1:0]                       status
);
    import frfc_pkg::*;

    localparam int PTR_W = $clog2(RING_BYTES);

    logic               mem_we;
    logic [PTR_W-1:0]   mem_waddr;
    logic [7:0]         mem_wdata;
    logic               mem_re;
    logic [PTR_W-1:0]   mem_raddr;
    logic [7:0]         mem_rdata;
    logic [PTR_W-1:0]   wp;
    logic [PTR_W-1:0]   rp;
    logic [PTR_W-1:0]   cp;
    logic [SLACK_W-1:0] slack;
    result_t            result;

    frfc_ctrl #(
        .RING_BYTES (RING_BYTES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .data_byte  (data_byte),
        .frame_kind (frame_kind),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .wp         (wp),
        .rp         (rp),
        .cp         (cp),
        .slack      (slack),
        .result     (result)
    );

    frfc_ram #(
        .RING_BYTES (RING_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    frfc_level #(
        .RING_BYTES (RING_BYTES)
    ) u_level (
        .wp         (wp),
        .rp         (rp),
        .cp         (cp),
        .slack      (slack),
        .free_bytes (free_bytes),
        .flush_due  (flush_due)
    );

    assign result_strobe = result.strobe;
    assign read_valid    = result.rvalid;
    assign read_byte     = result.rvalid ? mem_rdata : 8'd0;
    assign stream_done   = result.done;
    assign status        = result.status;

    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> !busy)
        else $error("result strobe while a request is still in progress");

    a_request_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (result_strobe || busy))
        else $error("accepted request neither completed nor in progress");

    a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && read_valid) |-> (status == STAT_OK))
        else $error("drained byte reported with an error status");

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && $past(result_strobe) && $past(stream_done)) |-> stream_done)
        else $error("done mark cleared");

endmodule
